@@ design/circ_pkg.sv @@
package circ_pkg;

    localparam int MAX_INTERVALS = 1024;
    localparam int COORD_BITS    = 16;
    localparam int ADDR_BITS     = $clog2(MAX_INTERVALS);
    localparam int CNT_BITS      = ADDR_BITS + 1;
    localparam int ENTRY_BITS    = 2 * COORD_BITS;

    typedef struct packed {
        logic load_new;
        logic rd_prev;
        logic shift;
        logic place;
        logic sweep_init;
        logic rd_sweep;
        logic sweep_acc;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic j_zero;
        logic goes_after;
        logic sweep_done;
        logic last;
    } t_status;

endpackage

@@ design/circ_datapath.sv @@
module circ_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  circ_pkg::t_cmd                      i_cmd,
    output circ_pkg::t_status                   o_status,
    input  logic [circ_pkg::COORD_BITS-1:0]     i_interval_start,
    input  logic [circ_pkg::COORD_BITS-1:0]     i_interval_end,
    input  logic                                i_last_of_set,
    output logic [circ_pkg::CNT_BITS-1:0]       o_remaining_count,
    output logic                                o_overflow
);

    logic [circ_pkg::ENTRY_BITS-1:0] r_mem [circ_pkg::MAX_INTERVALS];
    logic [circ_pkg::ENTRY_BITS-1:0] r_rdata;
    logic [circ_pkg::COORD_BITS-1:0] r_new_start, r_new_end, r_max_end;
    logic [circ_pkg::CNT_BITS-1:0]   r_loaded, r_j, r_i, r_count;
    logic                            r_ovf, r_last;

    logic [circ_pkg::CNT_BITS-1:0]   jm1;
    logic [circ_pkg::ADDR_BITS-1:0]  raddr, waddr;
    logic [circ_pkg::ENTRY_BITS-1:0] wdata;
    logic                            we;
    logic [circ_pkg::COORD_BITS-1:0] prev_start, prev_end;

    assign jm1        = r_j - circ_pkg::CNT_BITS'(1);
    assign prev_start = r_rdata[circ_pkg::ENTRY_BITS-1:circ_pkg::COORD_BITS];
    assign prev_end   = r_rdata[circ_pkg::COORD_BITS-1:0];

    always_comb begin
        raddr = i_cmd.rd_sweep ? r_i[circ_pkg::ADDR_BITS-1:0] : jm1[circ_pkg::ADDR_BITS-1:0];
        waddr = r_j[circ_pkg::ADDR_BITS-1:0];
        we    = i_cmd.shift | i_cmd.place;
        wdata = i_cmd.shift ? r_rdata : {r_new_start, r_new_end};
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_prev | i_cmd.rd_sweep) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_cmd.load_new && o_status.full) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.place) begin
                r_loaded <= r_loaded + circ_pkg::CNT_BITS'(1);
            end
            if (i_cmd.clear) begin
                r_loaded <= '0;
                r_ovf    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_new) begin
            r_new_start <= i_interval_start;
            r_new_end   <= i_interval_end;
            r_last      <= i_last_of_set;
            r_j         <= r_loaded;
        end
        if (i_cmd.shift) begin
            r_j <= jm1;
        end
        if (i_cmd.sweep_init) begin
            r_i       <= '0;
            r_count   <= '0;
            r_max_end <= '0;
        end
        if (i_cmd.sweep_acc) begin
            r_i <= r_i + circ_pkg::CNT_BITS'(1);
            if (r_count == '0 || r_max_end < prev_end) begin
                r_max_end <= prev_end;
                r_count   <= r_count + circ_pkg::CNT_BITS'(1);
            end
        end
    end

    always_comb begin
        o_status.full       = (r_loaded == circ_pkg::CNT_BITS'(circ_pkg::MAX_INTERVALS));
        o_status.j_zero     = (r_j == '0);
        o_status.goes_after = (prev_start > r_new_start) ||
                              (prev_start == r_new_start && prev_end < r_new_end);
        o_status.sweep_done = (r_i == r_loaded);
        o_status.last       = r_last;
    end

    assign o_remaining_count = r_count;
    assign o_overflow        = r_ovf;

endmodule

@@ design/circ_controller.sv @@
module circ_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_last_of_set,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output circ_pkg::t_cmd    o_cmd,
    input  circ_pkg::t_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_SW_RD, S_SW_CHK, S_RESULT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_new = 1'b1;
                    if (!i_status.full) begin
                        n_state = S_INS_RD;
                    end else if (i_last_of_set) begin
                        o_cmd.sweep_init = 1'b1;
                        n_state = S_SW_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (i_status.j_zero) begin
                    o_cmd.place = 1'b1;
                    if (i_status.last) begin
                        o_cmd.sweep_init = 1'b1;
                        n_state = S_SW_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_status.goes_after) begin
                    o_cmd.shift = 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    o_cmd.place = 1'b1;
                    if (i_status.last) begin
                        o_cmd.sweep_init = 1'b1;
                        n_state = S_SW_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SW_RD: begin
                if (i_status.sweep_done) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.rd_sweep = 1'b1;
                    n_state = S_SW_CHK;
                end
            end
            S_SW_CHK: begin
                o_cmd.sweep_acc = 1'b1;
                n_state = S_SW_RD;
            end
            S_RESULT: begin
                if (!i_stall) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_RESULT);

endmodule

@@ design/covered_interval_removal_count_unit.sv @@
// Counts the intervals of a set that no other interval covers. Intervals are
// kept in start-ascending, end-descending order by insertion into a single
// port memory as they arrive: each item reads the stored entries from the
// highest address down and moves each one that sorts after it up one place,
// then is written in the gap; o_stall holds off the next item meanwhile. An
// item that arrives on a full store is dropped. After the last item the sweep
// reads each stored entry once, then the result is held until transferred.
// Intervals beyond the store depth are dropped and flagged with o_overflow; a
// set always ends on its last item.
module covered_interval_removal_count_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [circ_pkg::COORD_BITS-1:0] i_interval_start,
    input  logic [circ_pkg::COORD_BITS-1:0] i_interval_end,
    input  logic                            i_last_of_set,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [circ_pkg::CNT_BITS-1:0]   o_remaining_count,
    output logic                            o_overflow
);

    circ_pkg::t_cmd    cmd;
    circ_pkg::t_status status;

    circ_controller u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_last_of_set (i_last_of_set),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_cmd         (cmd),
        .i_status      (status)
    );

    circ_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_interval_start  (i_interval_start),
        .i_interval_end    (i_interval_end),
        .i_last_of_set     (i_last_of_set),
        .o_remaining_count (o_remaining_count),
        .o_overflow        (o_overflow)
    );

endmodule

@@ tb/sv/tb_covered_interval_removal_count_unit.sv @@
`timescale 1ns / 100ps

module tb_covered_interval_removal_count_unit;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_interval_start;
    logic [15:0] i_interval_end;
    logic        i_last_of_set;
    logic        o_valid;
    logic        i_stall;
    logic [10:0] o_remaining_count;
    logic        o_overflow;

    typedef struct packed {
        logic [10:0] count;
        logic        ovf;
    } t_count_result;

    // predictor state: the current set as received
    logic [15:0]   set_start [$];
    logic [15:0]   set_end [$];
    logic          set_ovf;
    t_count_result pending_counts [$];
    int            mismatches;
    int            items_sent;
    bit            no_idle;

    covered_interval_removal_count_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_interval_start  (i_interval_start),
        .i_interval_end    (i_interval_end),
        .i_last_of_set     (i_last_of_set),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_remaining_count (o_remaining_count),
        .o_overflow        (o_overflow)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic [10:0] count_uncovered();
        logic [15:0] s [$];
        logic [15:0] e [$];
        logic [15:0] ts;
        logic [15:0] te;
        int          j;
        int          remain;
        logic [15:0] max_end;
        s = set_start;
        e = set_end;
        for (int i = 1; i < s.size(); i++) begin
            ts = s[i];
            te = e[i];
            j = i;
            while (j > 0 && (s[j-1] > ts || (s[j-1] == ts && e[j-1] < te))) begin
                s[j] = s[j-1];
                e[j] = e[j-1];
                j--;
            end
            s[j] = ts;
            e[j] = te;
        end
        remain = 0;
        max_end = '0;
        for (int i = 0; i < s.size(); i++) begin
            if (remain == 0 || max_end < e[i]) begin
                max_end = e[i];
                remain++;
            end
        end
        return remain[10:0];
    endfunction

    task automatic predict_interval(input logic [15:0] st, input logic [15:0] en,
                                    input logic last);
        t_count_result r;
        if (set_start.size() < circ_pkg::MAX_INTERVALS) begin
            set_start.push_back(st);
            set_end.push_back(en);
        end else begin
            set_ovf = 1'b1;
        end
        if (last) begin
            r.count = count_uncovered();
            r.ovf = set_ovf;
            pending_counts.push_back(r);
            set_start.delete();
            set_end.delete();
            set_ovf = 1'b0;
        end
    endtask

    task automatic send_interval(input logic [15:0] st, input logic [15:0] en,
                                 input logic last);
        while (!no_idle && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_interval_start <= st;
        i_interval_end <= en;
        i_last_of_set <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_interval(st, en, last);
        items_sent++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= (!no_idle && $urandom_range(99) < 6);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result count=%0d ovf=%0b",
                             o_remaining_count, o_overflow);
            end else begin
                if (o_remaining_count !== pending_counts[0].count ||
                    o_overflow !== pending_counts[0].ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result: expected count=%0d ovf=%0b, got count=%0d ovf=%0b",
                                 pending_counts[0].count, pending_counts[0].ovf,
                                 o_remaining_count, o_overflow);
                end
                void'(pending_counts.pop_front());
            end
        end
    end

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_counts.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_set(input int n, input int span);
        for (int k = 0; k < n; k++)
            send_interval(16'($urandom_range(span)), 16'($urandom_range(span)),
                          k == n - 1);
    endtask

    task automatic test_corners();
        send_interval(16'h0000, 16'hFFFF, 1'b1);
        send_interval(16'hFFFF, 16'h0000, 1'b1);
        // duplicates, start above end, nested, tie on start
        send_interval(16'd5, 16'd9, 1'b0);
        send_interval(16'd5, 16'd9, 1'b0);
        send_interval(16'd9, 16'd2, 1'b0);
        send_interval(16'd6, 16'd8, 1'b0);
        send_interval(16'd5, 16'd12, 1'b0);
        send_interval(16'hFFFF, 16'hFFFF, 1'b0);
        send_interval(16'h0000, 16'h0000, 1'b0);
        send_interval(16'hAAAA, 16'h5555, 1'b0);
        send_interval(16'h5555, 16'hAAAA, 1'b1);
        send_interval(16'd1, 16'd3, 1'b0);
        send_interval(16'd2, 16'd4, 1'b0);
        send_interval(16'd3, 16'd5, 1'b1);
    endtask

    task automatic test_random_sets();
        for (int n = 0; n < 120; n++) begin
            if (n == 50) no_idle = 1'b1;
            if (n == 75) no_idle = 1'b0;
            if ($urandom_range(1))
                random_set($urandom_range(1, 12), 40);
            else
                random_set($urandom_range(1, 12), 16'hFFFF);
        end
    endtask

    // full store, plus dropped intervals and a dropped last item
    task automatic test_overflow();
        wait_drained();
        random_set(circ_pkg::MAX_INTERVALS + 3, 300);
        wait_drained();
        send_interval(16'd1, 16'd2, 1'b1);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_interval_start = '0;
        i_interval_end = '0;
        i_last_of_set = 1'b0;
        set_ovf = 1'b0;
        mismatches = 0;
        items_sent = 0;
        no_idle = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_random_sets();
        test_overflow();
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_counts.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #200ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
